### src/npcs_pkg.sv
// Shared types, constants and codes for the nearest palette colour search block.
package npcs_pkg;

    // Palette store geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    // Largest number of slots one search can visit
    localparam int SCAN_MAX = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;
    localparam int SCAN_AW  = (SCAN_MAX > 1) ? $clog2(SCAN_MAX) : 1;
    localparam int CNT_W    = $clog2(SCAN_MAX + 1);

    // Field widths
    localparam int COMP_W  = 16;
    localparam int SLOT_W  = 8;
    localparam int IDX_W   = 8;
    localparam int SQ_W    = 2 * COMP_W;
    localparam int DIST_W  = 34;
    localparam int COUNT_W = 9;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIST_W;
    localparam logic [CFG_IDX_W-1:0] CFG_SWATCH_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE_SQ = 1'd1;

    // Item commands
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } swatch_t;

    // Travels alongside each slot through the read and distance stages
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
    } scan_tag_t;

endpackage

### src/npcs_if.sv
// Handshake channel interfaces: item requests, results and register writes.
interface npcs_req_if;
    import npcs_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [SLOT_W-1:0] slot;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;

    modport source (output valid, cmd, slot, red, green, blue, input ready);
    modport sink   (input valid, cmd, slot, red, green, blue, output ready);
endinterface

interface npcs_rsp_if;
    import npcs_pkg::*;
    logic              valid;
    logic              ready;
    logic              found;
    logic [IDX_W-1:0]  match_index;
    logic [DIST_W-1:0] match_distance_sq;

    modport source (output valid, found, match_index, match_distance_sq, input ready);
    modport sink   (input valid, found, match_index, match_distance_sq, output ready);
endinterface

interface npcs_cfg_if;
    import npcs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/npcs_palette_mem.sv
// Palette swatch store: one write port, one registered read port.
module npcs_palette_mem
(
    input  logic                      clk,
    input  logic                      we,
    input  logic [npcs_pkg::PAL_AW-1:0] waddr,
    input  npcs_pkg::swatch_t         wdata,
    input  logic [npcs_pkg::PAL_AW-1:0] raddr,
    output npcs_pkg::swatch_t         rdata
);
    import npcs_pkg::*;

    swatch_t mem [PALETTE_DEPTH];
    swatch_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/npcs_dist_unit.sv
// Shared squared-distance datapath: abs diff, square, sum; one slot per cycle.
module npcs_dist_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  npcs_pkg::swatch_t             query,
    input  npcs_pkg::swatch_t             swatch,
    input  npcs_pkg::scan_tag_t           tag_in,
    output npcs_pkg::scan_tag_t           tag_out,
    output logic [npcs_pkg::DIST_W-1:0]   dist_sq,
    output logic                          busy
);
    import npcs_pkg::*;

    scan_tag_t         s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic [COMP_W-1:0] dr_reg, dg_reg, db_reg;
    logic [SQ_W-1:0]   sr_reg, sg_reg, sb_reg;
    logic [DIST_W-1:0] sum_reg;
    logic [COMP_W-1:0] dr_next, dg_next, db_next;

    always_comb
    begin
        dr_next = (swatch.red   >= query.red)   ? swatch.red   - query.red
                                                : query.red   - swatch.red;
        dg_next = (swatch.green >= query.green) ? swatch.green - query.green
                                                : query.green - swatch.green;
        db_next = (swatch.blue  >= query.blue)  ? swatch.blue  - query.blue
                                                : query.blue  - swatch.blue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg <= tag_in;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg  <= dr_next;
        dg_reg  <= dg_next;
        db_reg  <= db_next;
        sr_reg  <= dr_reg * dr_reg;
        sg_reg  <= dg_reg * dg_reg;
        sb_reg  <= db_reg * db_reg;
        sum_reg <= DIST_W'(sr_reg) + DIST_W'(sg_reg) + DIST_W'(sb_reg);
    end

    assign tag_out = s3_tag_reg;
    assign dist_sq = sum_reg;
    assign busy    = s1_tag_reg.valid | s2_tag_reg.valid | s3_tag_reg.valid;

endmodule

### src/nearest_palette_color_search.sv
// Timing: rsp.valid rises once the result register loads. A write or an empty search
// goes straight to the result wait; a search with n = min(swatch_count, 256) issues n slot
// reads, drains the read and distance pipe, then loads the result register, which waits
// while an earlier result is unaccepted. One item at a time; the next transfer is taken
// only once the sequencer is idle again. Reset: asynchronous, active low; clears control
// and both config registers. The palette store is not cleared; write before searching.
module nearest_palette_color_search
(
    input  logic             clk,
    input  logic             rst_n,
    npcs_req_if.sink         req,
    npcs_rsp_if.source       rsp,
    npcs_cfg_if.sink         cfg
);
    import npcs_pkg::*;

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;   // issuing slot reads
    localparam logic [1:0] ST_DRAIN = 2'd2;   // waiting for the distance pipe to empty
    localparam logic [1:0] ST_DONE  = 2'd3;   // result waiting for the output register

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   n_eff;
    swatch_t            query_reg, query_next;

    // Running best match
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]  best_dist_reg, best_dist_next;

    // Configuration registers
    logic [COUNT_W-1:0] swatch_count_reg;
    logic [DIST_W-1:0]  tolerance_sq_reg;

    // Result register
    logic               rsp_valid_reg, rsp_valid_next;
    logic               rsp_found_reg;
    logic [IDX_W-1:0]   rsp_index_reg;
    logic [DIST_W-1:0]  rsp_dist_reg;
    logic               rsp_load;

    // Palette and datapath
    logic               req_xfer;
    logic               mem_we;
    swatch_t            req_swatch;
    swatch_t            rd_swatch;
    logic [PAL_AW-1:0]  rd_addr;
    scan_tag_t          issue_tag;
    scan_tag_t          rd_tag_reg;
    scan_tag_t          dist_tag;
    logic [DIST_W-1:0]  dist_sq;
    logic               dist_busy;
    logic               take;

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_xfer   = req.valid & req.ready;
    assign req_swatch = '{red: req.red, green: req.green, blue: req.blue};

    // Slots past the store are dropped silently
    assign mem_we = req_xfer && (req.cmd == CMD_WRITE) && (int'(req.slot) < PALETTE_DEPTH);

    // Slots scanned: count clamped to what the store can index
    assign n_eff = (int'(swatch_count_reg) > SCAN_MAX) ? CNT_W'(SCAN_MAX)
                                                       : CNT_W'(swatch_count_reg);

    assign rd_addr         = PAL_AW'(scan_cnt_reg[SCAN_AW-1:0]);
    assign issue_tag.valid = (state_reg == ST_SCAN);
    assign issue_tag.index = IDX_W'(scan_cnt_reg);

    npcs_palette_mem u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (PAL_AW'(req.slot)),
        .wdata (req_swatch),
        .raddr (rd_addr),
        .rdata (rd_swatch)
    );

    npcs_dist_unit u_dist
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query_reg),
        .swatch  (rd_swatch),
        .tag_in  (rd_tag_reg),
        .tag_out (dist_tag),
        .dist_sq (dist_sq),
        .busy    (dist_busy)
    );

    // Strict less-than keeps the lowest index on a tie
    assign take = dist_tag.valid && (dist_sq <= tolerance_sq_reg)
                  && (!found_reg || (dist_sq < best_dist_reg));

    assign rsp_load = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        n_next         = n_reg;
        query_next     = query_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    found_next     = 1'b0;
                    best_idx_next  = '0;
                    best_dist_next = '0;
                    scan_cnt_next  = '0;
                    if (req.cmd == CMD_SEARCH)
                    begin
                        query_next = req_swatch;
                        n_next     = n_eff;
                        state_next = (n_eff == '0) ? ST_DONE : ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_next == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_tag_reg.valid && !dist_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (take)
        begin
            found_next     = 1'b1;
            best_idx_next  = dist_tag.index;
            best_dist_next = dist_sq;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_cnt_reg     <= '0;
            n_reg            <= '0;
            found_reg        <= 1'b0;
            rd_tag_reg       <= '0;
            rsp_valid_reg    <= 1'b0;
            swatch_count_reg <= '0;
            tolerance_sq_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            n_reg         <= n_next;
            found_reg     <= found_next;
            rd_tag_reg    <= issue_tag;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_SWATCH_COUNT: swatch_count_reg <= cfg.data[COUNT_W-1:0];
                    CFG_TOLERANCE_SQ: tolerance_sq_reg <= cfg.data[DIST_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        query_reg     <= query_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        if (rsp_load)
        begin
            rsp_found_reg <= found_reg;
            rsp_index_reg <= best_idx_reg;
            rsp_dist_reg  <= best_dist_reg;
        end
    end

    assign cfg.ready             = 1'b1;
    assign rsp.valid             = rsp_valid_reg;
    assign rsp.found             = rsp_found_reg;
    assign rsp.match_index       = rsp_index_reg;
    assign rsp.match_distance_sq = rsp_dist_reg;

    // Scan counter stays inside the slot range of the running search
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg < n_reg))
        else $error("scan counter beyond slot count");

    // Nothing left in flight once the sequencer is idle again
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!rd_tag_reg.valid && !dist_busy))
        else $error("distance pipe busy while idle");

    // A miss reports zero index and zero distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_found_reg) |-> (rsp_index_reg == '0 && rsp_dist_reg == '0))
        else $error("non-zero fields on a miss");

endmodule
